// ----- src/crt_pkg.sv -----
// ----------------------------------------------------------------------------
// crt_pkg
// Shared types and constants for the chunk reassembly tracker.
// ----------------------------------------------------------------------------
package crt_pkg;

  // frame operation codes
  localparam logic [2:0] OP_LAYER_OPEN  = 3'd0;
  localparam logic [2:0] OP_CHUNK       = 3'd1;
  localparam logic [2:0] OP_COMPUTE     = 3'd2;
  localparam logic [2:0] OP_DONE        = 3'd3;

  // payload lengths that carry the size word and the full descriptor
  localparam logic [7:0] PLEN_SIZE = 8'd4;
  localparam logic [7:0] PLEN_FULL = 8'd10;

  // seen bitmap is stored as rows of eight bits
  localparam int ROW_SHIFT = 3;
  localparam int ROW_BITS  = 1 << ROW_SHIFT;

  typedef struct packed {
    logic [2:0]        op;
    logic [7:0]        frame_len;
    logic [7:0]        layer;
    logic [15:0]       frag_id;
    logic [15:0]       frag_total;
    logic [7:0]        payload_len;
    logic [31:0]       recv_size;
    logic              sparse_in;
    logic [31:0]       dense_size;
    logic signed [7:0] zp_in;
  } crt_in_t;

  typedef struct packed {
    logic              compute_start;
    logic              write_enable;
    logic [17:0]       write_offset;
    logic              dropped;
    logic [9:0]        unique_count;
    logic [15:0]       total_count;
    logic [7:0]        active_layer;
    logic [31:0]       size_out;
    logic              sparse_out;
    logic [31:0]       dense_out;
    logic signed [7:0] zero_out;
  } crt_out_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_EXEC
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic calc;
    logic exec;
    logic clr;
  } crt_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
    logic new_layer;
  } crt_status_t;

endpackage

// ----- src/crt_if.sv -----
// ----------------------------------------------------------------------------
// crt_if
// Valid/ready channels for frames in and tracker results out.
// ----------------------------------------------------------------------------
interface crt_in_if import crt_pkg::*; ();
  logic    valid;
  logic    ready;
  crt_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface crt_out_if import crt_pkg::*; ();
  logic     valid;
  logic     ready;
  crt_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/crt_ctrl.sv -----
// ----------------------------------------------------------------------------
// crt_ctrl
// Sequencer: bitmap clear sweep, frame capture, bitmap read, update.
// ----------------------------------------------------------------------------
module crt_ctrl import crt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  crt_status_t status,
  output crt_cmd_t    cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (status.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CALC;
      end
      ST_CALC: begin
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        // a new layer wipes the bitmap before the next frame
        if (status.out_free) state_nxt = status.new_layer ? ST_CLEAR : ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
      end
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_CALC: begin
        cmd.calc = 1'b1;
      end
      ST_EXEC: begin
        cmd.exec = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- src/crt_datapath.sv -----
// ----------------------------------------------------------------------------
// crt_datapath
// Frame register, seen bitmap memory, layer state and result register.
// ----------------------------------------------------------------------------
module crt_datapath import crt_pkg::*; #(
  parameter int MAX_CHUNKS   = 512,
  parameter int CHUNK_BYTES  = 240,
  parameter int BUF_BYTES    = 262144,
  parameter int HEADER_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  crt_in_t     in_data,
  input  crt_cmd_t    cmd,
  output crt_status_t status,
  input  logic        out_ready,
  output logic        out_valid,
  output crt_out_t    out_data
);

  localparam int IDX_W  = $clog2(MAX_CHUNKS);
  localparam int NROWS  = (MAX_CHUNKS + ROW_BITS - 1) / ROW_BITS;
  localparam int ROW_AW = (NROWS > 1) ? $clog2(NROWS) : 1;
  localparam int OFF_W  = $clog2(MAX_CHUNKS * CHUNK_BYTES);
  localparam int SUM_W  = ((OFF_W > 21) ? OFF_W : 21) + 1;
  localparam int CNT_W  = $clog2(MAX_CHUNKS + 1);
  localparam int CMP_W  = (CNT_W > 16) ? CNT_W : 16;

  localparam logic [7:0]        HDR_LEN   = 8'(HEADER_BYTES);
  localparam logic [15:0]       ID_LIMIT  = 16'(MAX_CHUNKS);
  localparam logic [SUM_W-1:0]  BUF_LIMIT = SUM_W'(BUF_BYTES);
  localparam logic [OFF_W-1:0]  CB        = OFF_W'(CHUNK_BYTES);
  localparam logic [ROW_AW-1:0] ROW_LAST  = ROW_AW'(NROWS - 1);

  crt_in_t             in_r;
  logic [OFF_W-1:0]    off_r;
  logic [ROW_BITS-1:0] rdata_r;
  logic [ROW_BITS-1:0] seen_mem [NROWS];
  logic [ROW_AW-1:0]   clr_idx_r;
  logic [ROW_AW-1:0]   row;
  logic [ROW_SHIFT-1:0] bit_sel;

  logic              started_r, started_nxt;
  logic              req_r, req_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, cnt_inc;
  logic [15:0]       total_r, total_nxt;
  logic [7:0]        layer_r, layer_nxt;
  logic [31:0]       size_r, size_nxt;
  logic              sparse_r, sparse_nxt;
  logic [31:0]       dense_r, dense_nxt;
  logic signed [7:0] zero_r, zero_nxt;

  logic     out_valid_r;
  crt_out_t out_r, out_nxt;

  logic runt, is_ls, is_chunk, is_req, is_done;
  logic chunk_ok, in_map, hit, drop, seen_bit, first, fits, wen, pulse;

  assign row     = ROW_AW'(in_r.frag_id >> ROW_SHIFT);
  assign bit_sel = in_r.frag_id[ROW_SHIFT-1:0];

  always_ff @(posedge clk) begin
    if (cmd.capture) in_r <= in_data;
    if (cmd.calc) begin
      off_r   <= OFF_W'(in_r.frag_id[IDX_W-1:0]) * CB;
      rdata_r <= seen_mem[row];
    end
    if (cmd.clr) begin
      seen_mem[clr_idx_r] <= '0;
    end else if (cmd.exec && first) begin
      seen_mem[row] <= rdata_r | (ROW_BITS'(1) << bit_sel);
    end
  end

  // clear sweep, one row a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (cmd.clr) begin
      clr_idx_r <= (clr_idx_r == ROW_LAST) ? '0 : clr_idx_r + 1'b1;
    end
  end

  always_comb begin
    runt     = in_r.frame_len < HDR_LEN;
    is_ls    = (in_r.op == OP_LAYER_OPEN) && !runt;
    is_chunk = (in_r.op == OP_CHUNK) && !runt;
    is_req   = (in_r.op == OP_COMPUTE) && !runt;
    is_done  = (in_r.op == OP_DONE);
    chunk_ok = is_chunk && started_r && (in_r.frag_id < in_r.frag_total);
    in_map   = in_r.frag_id < ID_LIMIT;
    hit      = chunk_ok && in_map;
    drop     = chunk_ok && !in_map;
    seen_bit = rdata_r[bit_sel];
    first    = hit && !seen_bit;
    fits     = (SUM_W'(off_r) + SUM_W'(in_r.payload_len)) <= BUF_LIMIT;
    wen      = hit && fits;
    cnt_inc  = cnt_r + 1'b1;

    started_nxt = started_r;
    req_nxt     = req_r;
    cnt_nxt     = cnt_r;
    total_nxt   = total_r;
    layer_nxt   = layer_r;
    size_nxt    = size_r;
    sparse_nxt  = sparse_r;
    dense_nxt   = dense_r;
    zero_nxt    = zero_r;
    pulse       = 1'b0;

    if (is_ls) begin
      layer_nxt   = in_r.layer;
      started_nxt = 1'b1;
      cnt_nxt     = '0;
      req_nxt     = 1'b0;
      if (in_r.payload_len >= PLEN_SIZE) size_nxt = in_r.recv_size;
      if (in_r.payload_len >= PLEN_FULL) begin
        sparse_nxt = in_r.sparse_in;
        dense_nxt  = in_r.dense_size;
        zero_nxt   = in_r.zp_in;
      end else begin
        sparse_nxt = 1'b0;
        dense_nxt  = size_nxt;
      end
    end else if (hit) begin
      total_nxt = in_r.frag_total;
      if (!seen_bit) begin
        cnt_nxt = cnt_inc;
        if ((CMP_W'(cnt_inc) >= CMP_W'(in_r.frag_total)) && !req_r) begin
          req_nxt = 1'b1;
          pulse   = 1'b1;
        end
      end
    end else if (is_req) begin
      if (!req_r && started_r && (total_r != '0) &&
          (CMP_W'(cnt_r) >= CMP_W'(total_r))) begin
        req_nxt = 1'b1;
        pulse   = 1'b1;
      end
    end else if (is_done) begin
      started_nxt = 1'b0;
    end

    out_nxt.compute_start = pulse;
    out_nxt.write_enable  = wen;
    out_nxt.write_offset  = wen ? 18'(off_r) : '0;
    out_nxt.dropped       = drop;
    out_nxt.unique_count  = 10'(cnt_nxt);
    out_nxt.total_count   = total_nxt;
    out_nxt.active_layer  = layer_nxt;
    out_nxt.size_out      = size_nxt;
    out_nxt.sparse_out    = sparse_nxt;
    out_nxt.dense_out     = dense_nxt;
    out_nxt.zero_out      = zero_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      req_r     <= 1'b0;
      cnt_r     <= '0;
      total_r   <= '0;
      layer_r   <= '0;
      size_r    <= '0;
      sparse_r  <= 1'b0;
      dense_r   <= '0;
      zero_r    <= '0;
    end else if (cmd.exec) begin
      started_r <= started_nxt;
      req_r     <= req_nxt;
      cnt_r     <= cnt_nxt;
      total_r   <= total_nxt;
      layer_r   <= layer_nxt;
      size_r    <= size_nxt;
      sparse_r  <= sparse_nxt;
      dense_r   <= dense_nxt;
      zero_r    <= zero_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) out_r <= out_nxt;
  end

  assign status.clr_last  = (clr_idx_r == ROW_LAST);
  assign status.out_free  = !out_valid_r || out_ready;
  assign status.new_layer = is_ls;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- src/chunk_reassembly_tracker_unit.sv -----
// ----------------------------------------------------------------------------
// chunk_reassembly_tracker_unit
// Seen-chunk bookkeeping, write commands and compute trigger for a chunked
// broadcast.
// ----------------------------------------------------------------------------
//  channel  direction  payload     transfer when
//  in_ch    sink       crt_in_t    in_ch.valid && in_ch.ready
//  out_ch   source     crt_out_t   out_ch.valid && out_ch.ready
//
//  each frame passes capture, bitmap row read with offset multiply and update
//  before the next frame is taken; one result per frame
//  the bitmap is cleared one 8-bit row a cycle, all ceil(MAX_CHUNKS/8) rows
//  (64 by default), after reset and after every non-runt layer start frame
//  no frame is taken during a clear sweep
//  the result register frees the input side; the update step waits while a
//  previous result is still held
// ----------------------------------------------------------------------------
module chunk_reassembly_tracker_unit import crt_pkg::*; #(
  parameter int MAX_CHUNKS   = 512,
  parameter int CHUNK_BYTES  = 240,
  parameter int BUF_BYTES    = 262144,
  parameter int HEADER_BYTES = 8
) (
  input logic        clk,
  input logic        rst_n,
  crt_in_if.sink     in_ch,
  crt_out_if.source  out_ch
);

  crt_cmd_t    cmd;
  crt_status_t status;

  crt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  crt_datapath #(
    .MAX_CHUNKS   (MAX_CHUNKS),
    .CHUNK_BYTES  (CHUNK_BYTES),
    .BUF_BYTES    (BUF_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_ch.data),
    .cmd       (cmd),
    .status    (status),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_data  (out_ch.data)
  );

endmodule

// ----- src/crt_checker.sv -----
// ----------------------------------------------------------------------------
// crt_checker
// Port-level checks on the chunk reassembly tracker.
// ----------------------------------------------------------------------------
module crt_checker import crt_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input crt_out_t out_data
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // offset only meaningful with a write
  a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.write_enable |-> out_data.write_offset == '0)
    else $error("write offset without write");

  // a dropped chunk neither writes nor triggers
  a_drop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.dropped |->
      !out_data.write_enable && !out_data.compute_start)
    else $error("dropped chunk wrote or triggered");

  a_start_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.compute_start |-> out_data.total_count != '0)
    else $error("compute start with empty total");

  // clear sweep follows reset
  a_reset_sweep: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("frame taken before bitmap clear");

endmodule

bind chunk_reassembly_tracker_unit crt_checker u_crt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

// ----- verif/crt_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crt_monitor
// Watches both channels of the chunk reassembly tracker, keeps its own copy
// of the layer and bitmap state, works out the status each accepted frame
// should produce and compares it field by field with the returned status.
// ----------------------------------------------------------------------------
module crt_monitor import crt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  crt_in_if    in_ch,
  crt_out_if   out_ch,
  output int   mismatch_count,
  output int   outstanding
);

  localparam int MAP_DEPTH   = 512;
  localparam int CHUNK_SZ    = 240;
  localparam int BUF_SZ      = 262144;
  localparam int HDR_BYTES   = 8;
  localparam int PRINT_LIMIT = 40;

  // tracker state as the block should hold it
  logic [MAP_DEPTH-1:0] seen_bits;
  int                   unique_seen;
  logic [15:0]          announced_total;
  bit                   layer_open;
  bit                   compute_asked;
  logic [7:0]           layer_q;
  logic [31:0]          size_q;
  logic                 sparse_q;
  logic [31:0]          dense_q;
  logic signed [7:0]    zero_q;

  crt_out_t pending_status [$];
  crt_out_t want;
  crt_out_t next_status;

  task automatic clear_tracker();
    seen_bits       = '0;
    unique_seen     = 0;
    announced_total = '0;
    layer_open      = 1'b0;
    compute_asked   = 1'b0;
    layer_q         = '0;
    size_q          = '0;
    sparse_q        = 1'b0;
    dense_q         = '0;
    zero_q          = '0;
  endtask

  task automatic track_frame(input crt_in_t f, output crt_out_t r);
    bit runt;
    int off;
    runt = f.frame_len < HDR_BYTES;
    r    = '0;
    case (f.op)
      OP_LAYER_OPEN: if (!runt) begin
        layer_q       = f.layer;
        layer_open    = 1'b1;
        unique_seen   = 0;
        seen_bits     = '0;
        compute_asked = 1'b0;
        if (f.payload_len >= PLEN_SIZE) size_q = f.recv_size;
        if (f.payload_len >= PLEN_FULL) begin
          sparse_q = f.sparse_in;
          dense_q  = f.dense_size;
          zero_q   = f.zp_in;
        end else begin
          // short descriptor: dense size follows the received size
          sparse_q = 1'b0;
          dense_q  = size_q;
        end
      end
      OP_CHUNK: if (!runt && layer_open && f.frag_id < f.frag_total) begin
        if (f.frag_id >= MAP_DEPTH) begin
          r.dropped = 1'b1;
        end else begin
          off = int'(f.frag_id) * CHUNK_SZ;
          if (off + int'(f.payload_len) <= BUF_SZ) begin
            r.write_enable = 1'b1;
            r.write_offset = 18'(off);
          end
          announced_total = f.frag_total;
          if (!seen_bits[f.frag_id]) begin
            seen_bits[f.frag_id] = 1'b1;
            unique_seen++;
            if (unique_seen >= int'(announced_total) && !compute_asked) begin
              compute_asked   = 1'b1;
              r.compute_start = 1'b1;
            end
          end
        end
      end
      OP_COMPUTE: if (!runt) begin
        if (!compute_asked && layer_open && announced_total != 0 &&
            unique_seen >= int'(announced_total)) begin
          compute_asked   = 1'b1;
          r.compute_start = 1'b1;
        end
      end
      OP_DONE: layer_open = 1'b0;
      default: ;
    endcase
    r.unique_count = unique_seen[9:0];
    r.total_count  = announced_total;
    r.active_layer = layer_q;
    r.size_out     = size_q;
    r.sparse_out   = sparse_q;
    r.dense_out    = dense_q;
    r.zero_out     = zero_q;
  endtask

  task automatic check_field(input string nm, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
        $display("%0t: %s expected %0h actual %0h", $time, nm, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_tracker();
      pending_status.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_status.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= PRINT_LIMIT)
            $display("%0t: status transfer expected none actual %0h", $time, out_ch.data);
        end else begin
          want = pending_status.pop_front();
          check_field("compute_start", want.compute_start, out_ch.data.compute_start);
          check_field("write_enable",  want.write_enable,  out_ch.data.write_enable);
          check_field("write_offset",  want.write_offset,  out_ch.data.write_offset);
          check_field("dropped",       want.dropped,       out_ch.data.dropped);
          check_field("unique_count",  want.unique_count,  out_ch.data.unique_count);
          check_field("total_count",   want.total_count,   out_ch.data.total_count);
          check_field("active_layer",  want.active_layer,  out_ch.data.active_layer);
          check_field("size_out",      want.size_out,      out_ch.data.size_out);
          check_field("sparse_out",    want.sparse_out,    out_ch.data.sparse_out);
          check_field("dense_out",     want.dense_out,     out_ch.data.dense_out);
          check_field("zero_out",      want.zero_out,      out_ch.data.zero_out);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        track_frame(in_ch.data, next_status);
        pending_status.push_back(next_status);
      end
    end
    outstanding <= pending_status.size();
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Frame stimulus for the chunk reassembly tracker: a directed opening on the
// corner cases, then random layers of shuffled chunks with duplicates, stray
// ids and noise frames, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb;
  import crt_pkg::*;

  localparam int HDR_BYTES    = 8;
  localparam int RANDOM_ITEMS = 1550;
  // a layer start sweep plus the longest gap and stall stays well below this
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 100;
  localparam logic [2:0] OP_OTHER = 3'd4;
  localparam logic [2:0] FRAME_OPS [3] = '{OP_LAYER_OPEN, OP_CHUNK, OP_COMPUTE};

  logic clk = 1'b0;
  logic rst_n;
  int   mismatch_count;
  int   outstanding;
  int   useful_frames;
  int   ready_hold;
  int   idle_cycles;
  bit   calm;
  bit   drained;

  crt_in_if  in_ch ();
  crt_out_if out_ch ();

  chunk_reassembly_tracker_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  crt_monitor status_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // mostly short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold     <= ready_hold - 1;
      out_ch.ready   <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < 20) begin
      ready_hold     <= idle_len() - 1;
      out_ch.ready   <= 1'b0;
    end else begin
      out_ch.ready   <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic crt_in_t rand_frame(input logic [2:0] op);
    crt_in_t f;
    f.op           = op;
    f.frame_len    = 8'($urandom_range(HDR_BYTES, 255));
    f.layer        = 8'($urandom);
    f.frag_id      = 16'($urandom);
    f.frag_total   = 16'($urandom);
    f.payload_len  = 8'($urandom);
    f.recv_size    = $urandom;
    f.sparse_in    = 1'($urandom);
    f.dense_size   = $urandom;
    f.zp_in        = 8'($urandom);
    return f;
  endfunction

  function automatic crt_in_t chunk_frame(input logic [15:0] id, input logic [15:0] tot);
    crt_in_t f;
    f            = rand_frame(OP_CHUNK);
    f.frag_id    = id;
    f.frag_total = tot;
    return f;
  endfunction

  function automatic crt_in_t layer_frame(input logic [7:0] plen);
    crt_in_t f;
    f             = rand_frame(OP_LAYER_OPEN);
    f.payload_len = plen;
    return f;
  endfunction

  function automatic crt_in_t noise_frame();
    crt_in_t f;
    case ($urandom_range(0, 3))
      0: begin
        f           = rand_frame(FRAME_OPS[$urandom_range(0, 2)]);
        f.frame_len = 8'($urandom_range(0, HDR_BYTES - 1));
      end
      1: f = rand_frame(OP_OTHER);
      2: f = rand_frame(OP_CHUNK);
      default: begin
        f           = rand_frame(OP_DONE);
        f.frame_len = 8'($urandom);
      end
    endcase
    return f;
  endfunction

  task automatic send_frame(input crt_in_t f);
    int gap;
    gap = (calm || $urandom_range(0, 1)) ? 0 : idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= f;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (f.op == OP_DONE || (f.op != OP_OTHER && f.frame_len >= HDR_BYTES))
      useful_frames++;
  endtask

  task automatic directed_frames();
    crt_in_t f;
    send_frame(chunk_frame(16'd0, 16'd4));        // chunk with no layer open
    f = layer_frame(8'd12);
    f.frame_len = 8'(HDR_BYTES - 1);               // runt layer start
    send_frame(f);
    f = layer_frame(8'd3);
    f.layer = 8'hff;
    f.frame_len = 8'(HDR_BYTES);
    send_frame(f);
    f = layer_frame(8'd4);
    f.recv_size = '1;
    f.frame_len = 8'hff;
    send_frame(f);
    f = layer_frame(8'd10);
    f.layer = 8'd0;
    f.sparse_in = 1'b1;
    f.dense_size = '1;
    f.zp_in = -8'sd128;
    send_frame(f);
    f = layer_frame(8'd255);
    f.sparse_in = 1'b0;
    f.dense_size = '0;
    f.zp_in = 8'sd127;
    send_frame(f);
    send_frame(chunk_frame(16'd0, 16'd0));        // id not below the total
    f = chunk_frame(16'd511, 16'hffff);
    f.payload_len = 8'hff;
    send_frame(f);
    send_frame(chunk_frame(16'd512, 16'd513));    // beyond the bitmap
    send_frame(chunk_frame(16'hfffe, 16'hffff));
    send_frame(chunk_frame(16'd0, 16'd3));
    send_frame(chunk_frame(16'd0, 16'd3));        // repeat of a seen chunk
    f = chunk_frame(16'd1, 16'd3);
    f.frame_len = 8'd0;
    send_frame(f);
    send_frame(rand_frame(OP_COMPUTE));           // still incomplete
    send_frame(chunk_frame(16'd1, 16'd3));        // completes the layer
    send_frame(rand_frame(OP_COMPUTE));           // already requested
    send_frame(layer_frame(8'd10));
    send_frame(chunk_frame(16'd0, 16'd10));
    send_frame(chunk_frame(16'd1, 16'd10));
    send_frame(chunk_frame(16'd2, 16'd10));
    send_frame(chunk_frame(16'd0, 16'd1));        // total drops under the count
    send_frame(rand_frame(OP_COMPUTE));           // request is what triggers here
    f = rand_frame(OP_DONE);
    f.frame_len = 8'd0;
    send_frame(f);
    send_frame(chunk_frame(16'd3, 16'd10));       // layer closed
    send_frame(rand_frame(OP_COMPUTE));
    send_frame(rand_frame(OP_OTHER));
  endtask

  task automatic run_layer();
    int          tot, n, k, j, r;
    logic [15:0] order [$];
    logic [15:0] tmp;
    crt_in_t     f;
    r = $urandom_range(0, 99);
    if (r < 80) tot = $urandom_range(1, 12);
    else if (r < 95) tot = $urandom_range(13, 64);
    else tot = $urandom_range(500, 530);
    r = $urandom_range(0, 99);
    if (r < 25) send_frame(layer_frame(8'($urandom_range(0, 3))));
    else if (r < 50) send_frame(layer_frame(8'($urandom_range(4, 9))));
    else send_frame(layer_frame(8'($urandom_range(10, 255))));
    if (tot <= 64) begin
      for (k = 0; k < tot; k++) order.push_back(16'(k));
      for (k = tot - 1; k > 0; k--) begin
        j        = $urandom_range(0, k);
        tmp      = order[k];
        order[k] = order[j];
        order[j] = tmp;
      end
      // now and then the layer stays one chunk short
      if ($urandom_range(0, 9) == 0) void'(order.pop_back());
      n = $urandom_range(0, tot / 3);
      for (k = 0; k < n; k++)
        order.insert($urandom_range(0, order.size()), 16'($urandom_range(0, tot - 1)));
    end else begin
      // ids around the top of the bitmap, past it when the total is above 512
      n = $urandom_range(20, 40);
      for (k = 0; k < n; k++) order.push_back(16'($urandom_range(tot - 30, tot - 1)));
    end
    foreach (order[k]) begin
      r = $urandom_range(0, 99);
      if (r < 5) send_frame(noise_frame());
      f = chunk_frame(order[k], 16'(tot));
      if (r >= 5 && r < 8) f.frag_id = 16'(tot + $urandom_range(0, 3));
      else if (r >= 8 && r < 11) f.frag_total = 16'($urandom_range(1, tot + 4));
      send_frame(f);
    end
    if ($urandom_range(0, 1)) send_frame(rand_frame(OP_COMPUTE));
    if ($urandom_range(0, 2) == 0) send_frame(rand_frame(OP_DONE));
  endtask

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.data    = '0;
    out_ch.ready  = 1'b0;
    ready_hold    = 0;
    idle_cycles   = 0;
    useful_frames = 0;
    calm          = 1'b0;
    drained       = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    directed_frames();
    useful_frames = 0;
    while (useful_frames < RANDOM_ITEMS) begin
      calm <= ($urandom_range(0, 4) == 0);
      if (!drained && useful_frames > RANDOM_ITEMS / 2) begin
        // hold the sender until every status has come back
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        drained = 1'b1;
      end
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 4)) send_frame(noise_frame());
      end else begin
        run_layer();
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
